// ===== src/xw_pkg.sv =====
// types, constants and step functions shared by the xorwow generator
package xw_pkg;

    localparam int unsigned LANE_COUNT   = 5;
    localparam int unsigned WARMUP_STEPS = 8;
    localparam int unsigned WORD_WIDTH   = 32;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef word_t lanes_t [LANE_COUNT];

    localparam word_t WEYL_STEP = 32'h0005_87C5;

    localparam word_t SEED_MASKS [LANE_COUNT] = '{
        32'h0FFF_FFFF, 32'hFF0F_FFFF, 32'hFFF0_0FFF, 32'hFFFF_F0FF, 32'hFFFF_FFF0
    };

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } opcode_t;

    typedef struct packed {
        logic    valid;
        opcode_t opcode;
        word_t   seed;
    } item_t;

    // new newest lane word from the oldest and newest lanes
    function automatic word_t xw_fresh(input word_t oldest, input word_t newest);
        word_t t;
        t = oldest ^ (oldest >> 2);
        t = t ^ (t << 1);
        return t ^ newest ^ (newest << 4);
    endfunction

    // one step of the lanes, index 0 newest
    function automatic lanes_t xw_shift(input lanes_t lanes);
        lanes_t nxt;
        nxt[0] = xw_fresh(lanes[LANE_COUNT-1], lanes[0]);
        for (int i = 1; i < LANE_COUNT; i++)
        begin
            nxt[i] = lanes[i-1];
        end
        return nxt;
    endfunction

    // lanes after seeding and the warm-up steps
    function automatic lanes_t xw_seed_lanes(input word_t seed);
        lanes_t lanes;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            lanes[i] = word_t'(i + 1) + (seed & SEED_MASKS[i]);
        end
        for (int s = 0; s < WARMUP_STEPS; s++)
        begin
            lanes = xw_shift(lanes);
        end
        return lanes;
    endfunction

    localparam word_t WARMUP_WEYL = word_t'(WARMUP_STEPS * WEYL_STEP);

endpackage

// ===== src/xw_if.sv =====
// stream interfaces for commands and random words
interface xw_cmd_if;
    logic             valid;
    logic             ready;
    xw_pkg::opcode_t  opcode;
    xw_pkg::word_t    seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

interface xw_word_if;
    logic           valid;
    logic           ready;
    xw_pkg::word_t  random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ===== src/xw_in_stage.sv =====
// input register for command transactions
module xw_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    xw_cmd_if.sink        cmd,
    output xw_pkg::item_t item,
    input  logic          take
);
    import xw_pkg::*;

    logic    valid_reg;
    opcode_t opcode_reg;
    word_t   seed_reg;
    logic    load;

    assign cmd.ready = !valid_reg || take;
    assign load      = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load || (valid_reg && !take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opcode_reg <= cmd.opcode;
            seed_reg   <= cmd.seed_value;
        end
    end

    assign item = '{valid: valid_reg, opcode: opcode_reg, seed: seed_reg};

endmodule

// ===== src/xw_core.sv =====
// generator state, step logic and result register
module xw_core (
    input  logic          clk,
    input  logic          rst_n,
    input  xw_pkg::item_t item,
    output logic          take,
    xw_word_if.source     rsp
);
    import xw_pkg::*;

    lanes_t lanes_reg;
    lanes_t lanes_next;
    word_t  weyl_reg;
    word_t  weyl_next;
    logic   out_valid_reg;
    word_t  out_word_reg;
    logic   is_draw;

    assign is_draw = (item.opcode == OP_DRAW);
    assign take    = item.valid && (!is_draw || !out_valid_reg || rsp.ready);

    always_comb
    begin
        lanes_next = lanes_reg;
        weyl_next  = weyl_reg;
        if (take)
        begin
            if (is_draw)
            begin
                lanes_next = xw_shift(lanes_reg);
                weyl_next  = weyl_reg + WEYL_STEP;
            end
            else
            begin
                lanes_next = xw_seed_lanes(item.seed);
                weyl_next  = item.seed + WARMUP_WEYL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lanes_reg[i] <= word_t'(i + 1);
            end
            weyl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lanes_reg <= lanes_next;
            weyl_reg  <= weyl_next;
            if (take && is_draw)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_draw)
        begin
            out_word_reg <= lanes_next[0] + weyl_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;

    a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_draw |=> rsp.valid)
        else $error("draw transaction did not produce a result");

    a_draw_weyl: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_draw |=> weyl_reg == $past(weyl_reg) + WEYL_STEP)
        else $error("counter did not advance on draw");

    a_seed_weyl: assert property (@(posedge clk) disable iff (!rst_n)
        take && !is_draw |=> weyl_reg == $past(item.seed) + WARMUP_WEYL)
        else $error("counter wrong after reseed");

    a_word_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_draw |=> rsp.random_word == lanes_reg[0] + weyl_reg)
        else $error("result does not match new state");

    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && !is_draw && !rsp.valid |=> !rsp.valid)
        else $error("reseed produced a result");

endmodule

// ===== src/xorwow_prng_with_seeding.sv =====
// a draw command is registered in the input stage, then its word in the result register
// throughput: one command per cycle, draw or reseed, unless a draw waits on rsp.ready;
// eight warm-up steps are unrolled; one state register update per command sets the rate
// reset: lanes load 1 to 5, the counter clears, no command or result is held
// draws issued before any reseed run from the reset state
module xorwow_prng_with_seeding (
    input  logic       clk,
    input  logic       rst_n,
    xw_cmd_if.sink     cmd,
    xw_word_if.source  rsp
);
    import xw_pkg::*;

    item_t item;
    logic  take;

    xw_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .item  (item),
        .take  (take)
    );

    xw_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .rsp   (rsp)
    );

endmodule
